/* src/i2c_mts_pkg.sv */
// Shared types and constants of the I2C master transaction sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2c_mts_pkg;

    localparam int unsigned BYTE_W = 8;

    // Item kinds carried on the input tuser.
    localparam logic [2:0] KIND_LOAD    = 3'd0;
    localparam logic [2:0] KIND_START_W = 3'd1;
    localparam logic [2:0] KIND_START_R = 3'd2;
    localparam logic [2:0] KIND_STATUS  = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;

    // Bus status codes after masking off the low two bits.
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_ADR_W_ACK    = 8'h18;
    localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_ADR_R_ACK    = 8'h40;
    localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;
    localparam logic [7:0] ST_MASK         = 8'hfc;
    localparam logic [7:0] RW_BIT          = 8'h01;

    // Input word, first field in the highest bits.
    typedef struct packed {
        logic [6:0] pad;
        logic [7:0] rx_byte;
        logic [7:0] status;
        logic [4:0] length;
        logic [7:0] value;
        logic [3:0] index;
    } in_word_t;

    // Result word, first field in the highest bits.
    typedef struct packed {
        logic [7:0] read_data;
        logic       fault;
        logic       done_res;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       release_flag;
        logic       irq_enable;
        logic       send_ack;
        logic       send_stop;
        logic       send_start;
    } out_word_t;

    // Access request to the message memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_req_t;

endpackage

`default_nettype wire

/* src/i2c_master_transaction_sequencer_unit.sv */
// Top level of the I2C master transaction sequencer.
//
// Usage: the input stream carries one word per host or bus event. tuser holds
// the kind (load byte, start write, start read, bus status event, read byte);
// tdata holds index, value, length, status and the received byte. For every
// accepted word exactly one result word leaves on the output stream, holding
// the bus control requests (start, stop, ack, interrupt enable, flag release),
// the byte to transmit, done and fault flags, and buffer read data.
// An accepted word is held in the input register; the decode, state update
// and buffer access then land in the result register, which presents the
// result word. Throughput is one word per cycle while the receiver does not
// stall; the single buffer port is used for at most one write or one read per word.
// Reset clears the pointer, lengths, pending-read flag and pair selection;
// the message buffer keeps whatever it held and must be loaded before use.
// When the receiver stalls, the result register holds its word, the input
// register takes one more word, and then tready drops until the output moves.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transaction_sequencer_unit #(
    parameter int unsigned BUF_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // index[3:0], value[11:4], length[16:12], status[24:17], rx_byte[32:25], zero[39:33]
    input  wire logic [39:0] s_tdata,
    // kind[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // send_start[0], send_stop[1], send_ack[2], irq_enable[3], release_flag[4],
    // tx_valid[5], tx_byte[13:6], done_res[14], fault[15], read_data[23:16]
    output logic [23:0]      m_tdata
);

    localparam int unsigned AW      = $clog2(BUF_DEPTH);
    localparam int unsigned PTR_W   = $clog2(BUF_DEPTH + 1);
    localparam int unsigned LEN_MAX = (BUF_DEPTH < 31) ? BUF_DEPTH : 31;
    localparam int unsigned LW      = $clog2(LEN_MAX + 1);
    localparam int unsigned CW      = (PTR_W > 5) ? PTR_W : 5;

    // Where the result byte comes from.
    localparam logic [1:0] SRC_NONE   = 2'd0;
    localparam logic [1:0] SRC_DIRECT = 2'd1;
    localparam logic [1:0] SRC_MEM    = 2'd2;

    typedef logic [i2c_mts_pkg::BYTE_W-1:0] byte_t;

    // Input register
    logic                  in_valid_reg;
    logic [2:0]            kind_reg;
    i2c_mts_pkg::in_word_t in_word_reg;

    // Sequencer state
    byte_t          buf0_reg,      buf0_next;
    byte_t          addr_copy_reg, addr_copy_next;
    byte_t          reg_number_reg, reg_number_next;
    logic           use_pair_reg,  use_pair_next;
    logic [PTR_W-1:0] ptr_reg,     ptr_next;
    logic [LW-1:0]  act_len_reg,   act_len_next;
    logic           pending_reg,   pending_next;
    logic [LW-1:0]  read_len_reg,  read_len_next;

    // Result register
    logic       out_valid_reg;
    logic       start_reg, start_next;
    logic       stop_reg,  stop_next;
    logic       ack_reg,   ack_next;
    logic       irq_reg,   irq_next;
    logic       rel_reg,   rel_next;
    logic       txv_reg,   txv_next;
    logic       done_reg,  done_next;
    logic       fault_reg, fault_next;
    logic       rd_sel_reg, rd_sel_next;
    logic [1:0] src_reg,   src_next;
    byte_t      direct_reg, direct_next;

    // Memory port
    i2c_mts_pkg::mem_req_t mem_req;
    logic [AW-1:0]         mem_addr;
    byte_t                 mem_wdata;
    byte_t                 mem_rdata;

    logic advance;
    logic proc;

    // Decode helpers
    logic [7:0]     stat;
    logic [CW-1:0]  idx_ext;
    logic           idx_ok;
    logic [LW-1:0]  len_clamped;
    logic [PTR_W-1:0] ptr_eff;
    logic           rx_put;
    logic [PTR_W-1:0] put_ptr;

    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            kind_reg    <= s_tuser;
            in_word_reg <= i2c_mts_pkg::in_word_t'(s_tdata);
        end
    end

    assign stat    = in_word_reg.status & i2c_mts_pkg::ST_MASK;
    assign idx_ext = CW'(in_word_reg.index);
    assign idx_ok  = idx_ext < CW'(BUF_DEPTH);

    // Length clamped to the buffer depth.
    always_comb begin
        if (CW'(in_word_reg.length) > CW'(BUF_DEPTH)) begin
            len_clamped = LW'(BUF_DEPTH);
        end else begin
            len_clamped = LW'(in_word_reg.length);
        end
    end

    // Decode of one word: state update, buffer access and result flags.
    always_comb begin
        buf0_next       = buf0_reg;
        addr_copy_next  = addr_copy_reg;
        reg_number_next = reg_number_reg;
        use_pair_next   = use_pair_reg;
        ptr_next        = ptr_reg;
        act_len_next    = act_len_reg;
        pending_next    = pending_reg;
        read_len_next   = read_len_reg;

        start_next  = 1'b0;
        stop_next   = 1'b0;
        ack_next    = 1'b0;
        irq_next    = 1'b0;
        rel_next    = 1'b0;
        txv_next    = 1'b0;
        done_next   = 1'b0;
        fault_next  = 1'b0;
        rd_sel_next = 1'b0;
        src_next    = SRC_NONE;
        direct_next = '0;

        mem_req.wr_en = 1'b0;
        mem_req.rd_en = 1'b0;
        mem_addr      = idx_ext[AW-1:0];
        mem_wdata     = in_word_reg.value;

        ptr_eff = ptr_reg;
        rx_put  = 1'b0;
        put_ptr = ptr_reg;

        case (kind_reg)
            i2c_mts_pkg::KIND_LOAD: begin
                if (idx_ok) begin
                    if (in_word_reg.index == '0) begin
                        buf0_next = in_word_reg.value;
                    end else begin
                        mem_req.wr_en = 1'b1;
                    end
                end
            end
            i2c_mts_pkg::KIND_START_W: begin
                pending_next  = 1'b0;
                use_pair_next = 1'b0;
                buf0_next     = buf0_reg & ~i2c_mts_pkg::RW_BIT;
                act_len_next  = len_clamped;
                start_next    = 1'b1;
                irq_next      = 1'b1;
                rel_next      = 1'b1;
            end
            i2c_mts_pkg::KIND_START_R: begin
                read_len_next   = len_clamped;
                pending_next    = 1'b1;
                addr_copy_next  = buf0_reg & ~i2c_mts_pkg::RW_BIT;
                reg_number_next = in_word_reg.value;
                use_pair_next   = 1'b1;
                act_len_next    = LW'(2);
                start_next      = 1'b1;
                irq_next        = 1'b1;
                rel_next        = 1'b1;
            end
            i2c_mts_pkg::KIND_STATUS: begin
                if (stat == i2c_mts_pkg::ST_START || stat == i2c_mts_pkg::ST_REP_START ||
                    stat == i2c_mts_pkg::ST_ADR_W_ACK ||
                    stat == i2c_mts_pkg::ST_DATA_TX_ACK) begin
                    // Transmit side: next byte, repeated start for a read, or stop.
                    if (stat == i2c_mts_pkg::ST_START || stat == i2c_mts_pkg::ST_REP_START) begin
                        ptr_eff = '0;
                    end
                    ptr_next = ptr_eff;
                    if (CW'(ptr_eff) < CW'(act_len_reg)) begin
                        txv_next = 1'b1;
                        irq_next = 1'b1;
                        rel_next = 1'b1;
                        ptr_next = ptr_eff + PTR_W'(1);
                        if (use_pair_reg) begin
                            src_next = SRC_DIRECT;
                            if (ptr_eff == PTR_W'(0)) begin
                                direct_next = addr_copy_reg;
                            end else if (ptr_eff == PTR_W'(1)) begin
                                direct_next = reg_number_reg;
                            end
                        end else if (CW'(ptr_eff) < CW'(BUF_DEPTH)) begin
                            if (ptr_eff == '0) begin
                                src_next    = SRC_DIRECT;
                                direct_next = buf0_reg;
                            end else begin
                                src_next      = SRC_MEM;
                                mem_req.rd_en = 1'b1;
                                mem_addr      = AW'(CW'(ptr_eff));
                            end
                        end
                    end else if (pending_reg) begin
                        pending_next  = 1'b0;
                        use_pair_next = 1'b0;
                        buf0_next     = buf0_reg | i2c_mts_pkg::RW_BIT;
                        act_len_next  = read_len_reg;
                        ptr_next      = PTR_W'(1);
                        start_next    = 1'b1;
                        irq_next      = 1'b1;
                        rel_next      = 1'b1;
                    end else begin
                        stop_next = 1'b1;
                        rel_next  = 1'b1;
                        done_next = 1'b1;
                    end
                end else if (stat == i2c_mts_pkg::ST_DATA_RX_ACK ||
                             stat == i2c_mts_pkg::ST_ADR_R_ACK) begin
                    // Receive side: store the byte and decide the next acknowledge.
                    if (stat == i2c_mts_pkg::ST_DATA_RX_ACK) begin
                        rx_put = 1'b1;
                        if (CW'(ptr_reg) < CW'(BUF_DEPTH)) begin
                            ptr_next = ptr_reg + PTR_W'(1);
                        end
                    end
                    irq_next = 1'b1;
                    rel_next = 1'b1;
                    if ((CW + 1)'(ptr_next) + (CW + 1)'(1) < (CW + 1)'(act_len_reg)) begin
                        ack_next = 1'b1;
                    end
                end else if (stat == i2c_mts_pkg::ST_DATA_RX_NACK) begin
                    rx_put    = 1'b1;
                    stop_next = 1'b1;
                    rel_next  = 1'b1;
                    done_next = 1'b1;
                end else if (stat == i2c_mts_pkg::ST_ARB_LOST) begin
                    start_next = 1'b1;
                    irq_next   = 1'b1;
                    rel_next   = 1'b1;
                end else begin
                    fault_next = 1'b1;
                end
            end
            i2c_mts_pkg::KIND_READ: begin
                rd_sel_next = 1'b1;
                if (idx_ok) begin
                    if (in_word_reg.index == '0) begin
                        src_next    = SRC_DIRECT;
                        direct_next = buf0_reg;
                    end else begin
                        src_next      = SRC_MEM;
                        mem_req.rd_en = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        // A received byte goes to the pair entry or to the buffer at the pointer.
        if (rx_put) begin
            mem_wdata = in_word_reg.rx_byte;
            if (use_pair_reg) begin
                if (put_ptr == PTR_W'(0)) begin
                    addr_copy_next = in_word_reg.rx_byte;
                end else if (put_ptr == PTR_W'(1)) begin
                    reg_number_next = in_word_reg.rx_byte;
                end
            end else if (CW'(put_ptr) < CW'(BUF_DEPTH)) begin
                if (put_ptr == '0) begin
                    buf0_next = in_word_reg.rx_byte;
                end else begin
                    mem_req.wr_en = 1'b1;
                    mem_addr      = AW'(CW'(put_ptr));
                end
            end
        end

        // The memory is touched only when the word really moves on.
        if (!proc) begin
            mem_req.wr_en = 1'b0;
            mem_req.rd_en = 1'b0;
        end
    end

    i2c_mts_msg_mem #(
        .DEPTH (BUF_DEPTH)
    ) u_msg_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Sequencer state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_copy_reg  <= '0;
            reg_number_reg <= '0;
            use_pair_reg   <= 1'b0;
            ptr_reg        <= '0;
            act_len_reg    <= '0;
            pending_reg    <= 1'b0;
            read_len_reg   <= '0;
        end else if (proc) begin
            addr_copy_reg  <= addr_copy_next;
            reg_number_reg <= reg_number_next;
            use_pair_reg   <= use_pair_next;
            ptr_reg        <= ptr_next;
            act_len_reg    <= act_len_next;
            pending_reg    <= pending_next;
            read_len_reg   <= read_len_next;
        end
        if (proc) begin
            buf0_reg <= buf0_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (proc) begin
            start_reg  <= start_next;
            stop_reg   <= stop_next;
            ack_reg    <= ack_next;
            irq_reg    <= irq_next;
            rel_reg    <= rel_next;
            txv_reg    <= txv_next;
            done_reg   <= done_next;
            fault_reg  <= fault_next;
            rd_sel_reg <= rd_sel_next;
            src_reg    <= src_next;
            direct_reg <= direct_next;
        end
    end

    // Result word assembly.
    byte_t                  out_byte;
    i2c_mts_pkg::out_word_t out_word;

    always_comb begin
        case (src_reg)
            SRC_DIRECT: out_byte = direct_reg;
            SRC_MEM:    out_byte = mem_rdata;
            default:    out_byte = '0;
        endcase
        out_word.send_start   = start_reg;
        out_word.send_stop    = stop_reg;
        out_word.send_ack     = ack_reg;
        out_word.irq_enable   = irq_reg;
        out_word.release_flag = rel_reg;
        out_word.tx_valid     = txv_reg;
        out_word.tx_byte      = txv_reg ? out_byte : '0;
        out_word.done_res     = done_reg;
        out_word.fault        = fault_reg;
        out_word.read_data    = rd_sel_reg ? out_byte : '0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word;

    // The pointer never runs past the buffer depth.
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PTR_W'(BUF_DEPTH))
        else $error("byte pointer beyond buffer depth");

    // While the address/register pair is selected, exactly two bytes are sent.
    a_pair_len: assert property (@(posedge aclk) disable iff (!aresetn)
        use_pair_reg |-> act_len_reg == LW'(2))
        else $error("pair selected with a length other than two");

    // A rejected status leaves the sequencer state untouched.
    a_fault_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && fault_next) |=> $stable(ptr_reg) && $stable(act_len_reg) &&
                                 $stable(use_pair_reg) && $stable(pending_reg))
        else $error("state changed on a rejected status");

    // A fault result carries no bus request.
    a_fault_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && fault_reg) |-> !(start_reg || stop_reg || rel_reg || irq_reg ||
                                           txv_reg || done_reg))
        else $error("fault reported together with a bus request");

    // A finished transaction always stops and releases the bus.
    a_done_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && done_reg) |-> (stop_reg && rel_reg && !start_reg))
        else $error("done without stop and release");

endmodule

`default_nettype wire

/* src/i2c_mts_msg_mem.sv */
// Message buffer memory with one shared write/read port and registered read data.
`timescale 1ns / 1ps
`default_nettype none

module i2c_mts_msg_mem #(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  wire logic                            aclk,
    input  wire i2c_mts_pkg::mem_req_t           req,
    input  wire logic [AW-1:0]                   addr,
    input  wire logic [i2c_mts_pkg::BYTE_W-1:0]  wdata,
    output logic      [i2c_mts_pkg::BYTE_W-1:0]  rdata
);

    logic [i2c_mts_pkg::BYTE_W-1:0] mem_reg [DEPTH];
    logic [i2c_mts_pkg::BYTE_W-1:0] rdata_reg;

    // The port either stores a byte or fetches one; the fetched byte holds until the next read.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[addr] <= wdata;
        end
        if (req.rd_en) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the I2C master transaction sequencer.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = 16;

    // One word for the input stream: kind on tuser, fields on tdata.
    typedef struct packed {
        logic [2:0]            kind;
        i2c_mts_pkg::in_word_t word;
    } host_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // index, value, length, status, rx_byte, zero pad
    logic [2:0]  s_tuser = '0;   // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // send_start .. fault, read_data in the top bits

    i2c_master_transaction_sequencer_unit #(
        .BUF_DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus and expectation stores.
    host_event_t            host_events[$];
    i2c_mts_pkg::out_word_t expected_results[$];
    int          items_queued = 0;
    int          items_accepted = 0;
    int          stimulus_count = 0;
    int          results_seen = 0;
    int          mismatches = 0;

    // Mirror of the sequencer state.
    logic [7:0] mirror_buf [DEPTH];
    logic [7:0] addr_byte = '0;
    logic [7:0] reg_byte = '0;
    bit         pair_sel = 1'b0;
    int         byte_ptr = 0;
    int         tx_len = 0;
    bit         read_armed = 1'b0;
    int         rd_len = 0;

    // Driver and monitor pacing.
    int         send_gap = 0;
    bit         tx_calm = 1'b0;
    int         rx_wait = 0;
    bit         rx_calm = 1'b0;
    int         hold_cnt = 0;
    bit         hold_done = 1'b0;
    i2c_mts_pkg::out_word_t want;
    i2c_mts_pkg::out_word_t got;

    initial begin
        for (int i = 0; i < DEPTH; i++) mirror_buf[i] = '0;
    end

    // Received bytes go to the address/register pair or to the buffer.
    function automatic void store_rx(int p, logic [7:0] v);
        if (pair_sel) begin
            if (p == 0) addr_byte = v;
            else if (p == 1) reg_byte = v;
        end else if (p < DEPTH) begin
            mirror_buf[p] = v;
        end
    endfunction

    // Works out the result word for one accepted input word and updates the mirror.
    function automatic i2c_mts_pkg::out_word_t next_bus_response(logic [2:0] kind,
                                                                 i2c_mts_pkg::in_word_t w);
        i2c_mts_pkg::out_word_t r;
        logic [7:0]             code;
        r = '0;
        code = w.status & i2c_mts_pkg::ST_MASK;
        case (kind)
            i2c_mts_pkg::KIND_LOAD: begin
                mirror_buf[w.index] = w.value;
            end
            i2c_mts_pkg::KIND_START_W: begin
                read_armed = 1'b0;
                pair_sel = 1'b0;
                mirror_buf[0] = mirror_buf[0] & ~i2c_mts_pkg::RW_BIT;
                tx_len = (w.length > DEPTH) ? DEPTH : int'(w.length);
                r.send_start = 1'b1;
                r.irq_enable = 1'b1;
                r.release_flag = 1'b1;
            end
            i2c_mts_pkg::KIND_START_R: begin
                rd_len = (w.length > DEPTH) ? DEPTH : int'(w.length);
                read_armed = 1'b1;
                addr_byte = mirror_buf[0] & ~i2c_mts_pkg::RW_BIT;
                reg_byte = w.value;
                pair_sel = 1'b1;
                tx_len = 2;
                r.send_start = 1'b1;
                r.irq_enable = 1'b1;
                r.release_flag = 1'b1;
            end
            i2c_mts_pkg::KIND_STATUS: begin
                if (code == i2c_mts_pkg::ST_START || code == i2c_mts_pkg::ST_REP_START ||
                    code == i2c_mts_pkg::ST_ADR_W_ACK ||
                    code == i2c_mts_pkg::ST_DATA_TX_ACK) begin
                    if (code == i2c_mts_pkg::ST_START || code == i2c_mts_pkg::ST_REP_START)
                        byte_ptr = 0;
                    if (byte_ptr < tx_len) begin
                        // Next byte from the pair or from the buffer.
                        r.tx_valid = 1'b1;
                        if (pair_sel)
                            r.tx_byte = (byte_ptr == 0) ? addr_byte :
                                        (byte_ptr == 1) ? reg_byte : 8'h00;
                        else
                            r.tx_byte = (byte_ptr < DEPTH) ? mirror_buf[byte_ptr] : 8'h00;
                        r.irq_enable = 1'b1;
                        r.release_flag = 1'b1;
                        byte_ptr++;
                    end else if (read_armed) begin
                        // Repeated start with the read bit set.
                        read_armed = 1'b0;
                        pair_sel = 1'b0;
                        mirror_buf[0] = mirror_buf[0] | i2c_mts_pkg::RW_BIT;
                        tx_len = rd_len;
                        byte_ptr = 1;
                        r.send_start = 1'b1;
                        r.irq_enable = 1'b1;
                        r.release_flag = 1'b1;
                    end else begin
                        r.send_stop = 1'b1;
                        r.release_flag = 1'b1;
                        r.done_res = 1'b1;
                    end
                end else if (code == i2c_mts_pkg::ST_DATA_RX_ACK ||
                             code == i2c_mts_pkg::ST_ADR_R_ACK) begin
                    if (code == i2c_mts_pkg::ST_DATA_RX_ACK) begin
                        store_rx(byte_ptr, w.rx_byte);
                        if (byte_ptr < DEPTH) byte_ptr++;
                    end
                    r.irq_enable = 1'b1;
                    r.release_flag = 1'b1;
                    if (byte_ptr + 1 < tx_len) r.send_ack = 1'b1;
                end else if (code == i2c_mts_pkg::ST_DATA_RX_NACK) begin
                    store_rx(byte_ptr, w.rx_byte);
                    r.send_stop = 1'b1;
                    r.release_flag = 1'b1;
                    r.done_res = 1'b1;
                end else if (code == i2c_mts_pkg::ST_ARB_LOST) begin
                    r.send_start = 1'b1;
                    r.irq_enable = 1'b1;
                    r.release_flag = 1'b1;
                end else begin
                    r.fault = 1'b1;
                end
            end
            i2c_mts_pkg::KIND_READ: begin
                r.read_data = mirror_buf[w.index];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Wait before the next word: none during calm stretches, else drawn at random.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 47) == 0) calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 7));
    endfunction

    task automatic check_field(string field_name, logic [7:0] exp_val, logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s expected %0h, got %0h", $time, field_name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Driver: presents queued words and predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(
                    next_bus_response(s_tuser, i2c_mts_pkg::in_word_t'(s_tdata)));
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (host_events.size() > 0) begin
                    s_tuser <= host_events[0].kind;
                    s_tdata <= host_events[0].word;
                    s_tvalid <= 1'b1;
                    void'(host_events.pop_front());
                    send_gap = draw_wait(tx_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_results.size() == 0) begin
                    $display("%0t: result word expected none, got %0h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("send_start", want.send_start, got.send_start);
                    check_field("send_stop", want.send_stop, got.send_stop);
                    check_field("send_ack", want.send_ack, got.send_ack);
                    check_field("irq_enable", want.irq_enable, got.irq_enable);
                    check_field("release_flag", want.release_flag, got.release_flag);
                    check_field("tx_valid", want.tx_valid, got.tx_valid);
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("fault", want.fault, got.fault);
                    check_field("read_data", want.read_data, got.read_data);
                end
                results_seen++;
                rx_wait = draw_wait(rx_calm);
            end
            // One long hold-off so that the block fills and stalls its input.
            if (results_seen == 400 && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic i2c_mts_pkg::in_word_t make_word(logic [3:0] idx, logic [7:0] val,
                                                        logic [4:0] len, logic [7:0] st,
                                                        logic [7:0] rx);
        i2c_mts_pkg::in_word_t w;
        w = '0;
        w.index = idx;
        w.value = val;
        w.length = len;
        w.status = st;
        w.rx_byte = rx;
        return w;
    endfunction

    function automatic i2c_mts_pkg::in_word_t rand_word();
        return make_word(4'($urandom), 8'($urandom), 5'($urandom_range(0, 16)),
                         8'($urandom), 8'($urandom));
    endfunction

    task automatic queue_event(logic [2:0] kind, i2c_mts_pkg::in_word_t w);
        host_event_t ev;
        ev.kind = kind;
        ev.word = w;
        host_events.push_back(ev);
        items_queued++;
        if (kind <= i2c_mts_pkg::KIND_READ) stimulus_count++;
    endtask

    // Status word with the given code and random low bits.
    task automatic status_event(logic [7:0] code);
        i2c_mts_pkg::in_word_t w;
        w = rand_word();
        w.status = code | 8'($urandom_range(0, 3));
        queue_event(i2c_mts_pkg::KIND_STATUS, w);
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 9))
            0: return i2c_mts_pkg::ST_START;
            1: return i2c_mts_pkg::ST_REP_START;
            2: return i2c_mts_pkg::ST_ADR_W_ACK;
            3: return i2c_mts_pkg::ST_DATA_TX_ACK;
            4: return i2c_mts_pkg::ST_ARB_LOST;
            5: return i2c_mts_pkg::ST_ADR_R_ACK;
            6: return i2c_mts_pkg::ST_DATA_RX_ACK;
            7: return i2c_mts_pkg::ST_DATA_RX_NACK;
            default: return 8'($urandom);
        endcase
    endfunction

    // Sends a run of status codes; now and then the run breaks off with a stray code.
    task automatic status_run(logic [7:0] codes[$]);
        int cut;
        cut = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, codes.size())) : -1;
        foreach (codes[i]) begin
            if (i == cut) begin
                status_event(pick_code());
                return;
            end
            status_event(codes[i]);
        end
    endtask

    task automatic write_transaction();
        int                    n;
        i2c_mts_pkg::in_word_t w;
        logic [7:0]            codes[$];
        n = $urandom_range(0, 16);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 2) != 0)
                queue_event(i2c_mts_pkg::KIND_LOAD,
                            make_word(4'(i), 8'($urandom), 5'($urandom_range(0, 16)),
                                      8'($urandom), 8'($urandom)));
        w = rand_word();
        w.length = 5'(n);
        queue_event(i2c_mts_pkg::KIND_START_W, w);
        codes.push_back(i2c_mts_pkg::ST_START);
        for (int i = 1; i <= n; i++)
            codes.push_back((i == 1) ? i2c_mts_pkg::ST_ADR_W_ACK : i2c_mts_pkg::ST_DATA_TX_ACK);
        status_run(codes);
        repeat ($urandom_range(0, 3)) queue_event(i2c_mts_pkg::KIND_READ, rand_word());
    endtask

    task automatic read_transaction();
        int                    n;
        i2c_mts_pkg::in_word_t w;
        logic [7:0]            codes[$];
        n = $urandom_range(0, 16);
        if ($urandom_range(0, 1) == 0)
            queue_event(i2c_mts_pkg::KIND_LOAD,
                        make_word(4'd0, 8'($urandom), 5'($urandom_range(0, 16)), 8'($urandom),
                                  8'($urandom)));
        w = rand_word();
        w.length = 5'(n);
        queue_event(i2c_mts_pkg::KIND_START_R, w);
        codes = '{i2c_mts_pkg::ST_START, i2c_mts_pkg::ST_ADR_W_ACK,
                  i2c_mts_pkg::ST_DATA_TX_ACK, i2c_mts_pkg::ST_REP_START};
        if (n >= 2) begin
            codes.push_back(i2c_mts_pkg::ST_ADR_R_ACK);
            for (int i = 0; i < n - 2; i++) codes.push_back(i2c_mts_pkg::ST_DATA_RX_ACK);
            // Receiving past the end of the buffer.
            if (n == 16 && $urandom_range(0, 1) == 0) begin
                codes.push_back(i2c_mts_pkg::ST_DATA_RX_ACK);
                codes.push_back(i2c_mts_pkg::ST_DATA_RX_ACK);
            end
            codes.push_back(i2c_mts_pkg::ST_DATA_RX_NACK);
        end
        status_run(codes);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 1) == 0)
                queue_event(i2c_mts_pkg::KIND_READ,
                            make_word(4'(i), 8'($urandom), 5'($urandom_range(0, 16)),
                                      8'($urandom), 8'($urandom)));
    endtask

    // Stray words of any kind, unknown kinds included.
    task automatic noise_word();
        i2c_mts_pkg::in_word_t w;
        logic [2:0]            kind;
        w = rand_word();
        kind = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        if (kind == i2c_mts_pkg::KIND_STATUS && $urandom_range(0, 1) == 0)
            w.status = pick_code() | 8'($urandom_range(0, 3));
        queue_event(kind, w);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (items_accepted != items_queued || expected_results.size() != 0);
    endtask

    // Stimulus sequence and end of run.
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Fill the whole buffer first, so that no entry is ever read unwritten.
        for (int i = 0; i < DEPTH; i++)
            queue_event(i2c_mts_pkg::KIND_LOAD, make_word(4'(i),
                        (i == 0) ? 8'hff : (i == DEPTH - 1) ? 8'h00 : 8'($urandom),
                        5'(i), 8'(i), 8'(i)));
        // Zero length write; acknowledge decision with zero length.
        queue_event(i2c_mts_pkg::KIND_START_W, make_word(4'd0, 8'h00, 5'd0, 8'h00, 8'h00));
        queue_event(i2c_mts_pkg::KIND_STATUS,
                    make_word(4'd0, 8'h00, 5'd0, i2c_mts_pkg::ST_ADR_R_ACK | 8'h03, 8'h00));
        queue_event(i2c_mts_pkg::KIND_STATUS,
                    make_word(4'd0, 8'h00, 5'd0, i2c_mts_pkg::ST_START, 8'h00));
        // Unexpected status codes, and lost arbitration.
        queue_event(i2c_mts_pkg::KIND_STATUS, make_word(4'd0, 8'h00, 5'd0, 8'h00, 8'h00));
        queue_event(i2c_mts_pkg::KIND_STATUS, make_word(4'hf, 8'hff, 5'd16, 8'hff, 8'hff));
        queue_event(i2c_mts_pkg::KIND_STATUS,
                    make_word(4'd0, 8'h00, 5'd0, i2c_mts_pkg::ST_ARB_LOST, 8'h00));
        // Unknown kinds.
        queue_event(3'd5, make_word(4'hf, 8'hff, 5'd16, 8'hff, 8'hff));
        queue_event(3'd7, make_word(4'hf, 8'hff, 5'd16, 8'hff, 8'hff));
        // Full-length read; a byte received while the pair is selected.
        queue_event(i2c_mts_pkg::KIND_START_R, make_word(4'd0, 8'hff, 5'd16, 8'h00, 8'h00));
        queue_event(i2c_mts_pkg::KIND_STATUS,
                    make_word(4'd0, 8'h00, 5'd0, i2c_mts_pkg::ST_DATA_RX_ACK, 8'h5a));
        status_event(i2c_mts_pkg::ST_START);
        status_event(i2c_mts_pkg::ST_ADR_W_ACK);
        status_event(i2c_mts_pkg::ST_DATA_TX_ACK);
        status_event(i2c_mts_pkg::ST_REP_START);
        queue_event(i2c_mts_pkg::KIND_READ, make_word(4'd0, 8'h00, 5'd0, 8'h00, 8'h00));
        queue_event(i2c_mts_pkg::KIND_READ, make_word(4'hf, 8'hff, 5'd16, 8'hff, 8'hff));

        // The sender pauses here until every expected word has come back.
        wait_drained();

        stimulus_count = 0;
        while (stimulus_count < 2000) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: write_transaction();
                4, 5, 6:    read_transaction();
                default:    repeat ($urandom_range(1, 4)) noise_word();
            endcase
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("i2c_master_transaction_sequencer_unit: match");
        end else begin
            $display("i2c_master_transaction_sequencer_unit: mismatch");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("i2c_master_transaction_sequencer_unit: mismatch");
        $finish;
    end

endmodule
